### hw/rtl/ic3_pkg.sv
// ic3_pkg: shared constants, types and helpers for the 3x3 convolution core.
// No dependencies. Used by every module of the block and by the checker.
package ic3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COEF_BITS   = 16;
  localparam int COEF_STRIDE = 16;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int KROW_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int CNT_W     = COL_W + ROW_W + 1;
  localparam int PROD_W    = PIX_W + COEF_BITS;
  localparam int CSUM_W    = PROD_W + 2;
  localparam int VAL_W     = 28;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [DIM_W-1:0]  DIM_RESET      = 11'd1024;
  localparam logic [KROW_W-1:0] KROW_RESET     = 48'd0;
  localparam logic [KROW_W-1:0] KROW_MID_RESET = 48'd4096;

  typedef logic [PIX_W-1:0]            pix_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  // one window column, top row first
  typedef struct packed {
    pix_t older;
    pix_t prev;
    pix_t cur;
  } column_t;

  typedef struct packed {
    logic       col_ok;
    logic [2:0] row_ok;
  } tap_mask_t;

  typedef struct packed {
    logic             have;
    logic             last;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             xl_ok;
    logic             xr_ok;
    logic [2:0]       row_ok;
  } res_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(maxv)) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hw/rtl/ic3_line_store.sv
// ic3_line_store: two row memories with read-modify-write per column.
// Depends on ic3_pkg. Presents the new window column one stage after accept.
module ic3_line_store import ic3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_v,
  input  logic [COL_W-1:0] in_col,
  input  pix_t             in_px,
  output logic             col_v,
  output column_t          col_o
);

  pix_t prev_mem  [MAX_WIDTH];
  pix_t older_mem [MAX_WIDTH];

  logic             v_r;
  logic             byp_r;
  logic [COL_W-1:0] col_r;
  pix_t             px_r;
  pix_t             prev_rd_r;
  pix_t             older_rd_r;
  pix_t             last_px_r;
  pix_t             last_prev_r;
  pix_t             prev_now;
  pix_t             older_now;

  // back-to-back hit on the same column (single-column rows)
  assign prev_now  = byp_r ? last_px_r   : prev_rd_r;
  assign older_now = byp_r ? last_prev_r : older_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      byp_r <= 1'b0;
    end else if (adv) begin
      v_r   <= in_v;
      byp_r <= in_v && v_r && (col_r == in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= in_col;
      px_r  <= in_px;
      if (v_r) begin
        last_px_r   <= px_r;
        last_prev_r <= prev_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_v) begin
        prev_rd_r  <= prev_mem[in_col];
        older_rd_r <= older_mem[in_col];
      end
      if (v_r) begin
        prev_mem[col_r]  <= px_r;
        older_mem[col_r] <= prev_now;
      end
    end
  end

  assign col_v = v_r;
  assign col_o = '{older: older_now, prev: prev_now, cur: px_r};

endmodule

### hw/rtl/ic3_cell.sv
// ic3_cell: one window column cell; holds three samples, passes them on,
// and forms the masked column partial sum. Depends on ic3_pkg.
module ic3_cell import ic3_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic                     shift,
  input  column_t                  col_i,
  input  tap_mask_t                mask,
  input  coef_t                    coef [3],
  output column_t                  col_o,
  output logic signed [CSUM_W-1:0] csum
);

  column_t                  col_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [PROD_W-1:0] prod   [3];
  logic signed [CSUM_W-1:0] csum_r;
  pix_t                     smp    [3];

  assign smp[0] = col_r.older;
  assign smp[1] = col_r.prev;
  assign smp[2] = col_r.cur;

  always_comb begin
    logic signed [PROD_W:0] full;
    pix_t                   px_m;
    for (int j = 0; j < 3; j++) begin
      px_m    = (mask.col_ok && mask.row_ok[j]) ? smp[j] : '0;
      full    = $signed({1'b0, px_m}) * coef[j];
      prod[j] = $signed(full[PROD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_i;
    end
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= prod[j];
      end
      csum_r <= CSUM_W'(prod_r[0]) + CSUM_W'(prod_r[1]) + CSUM_W'(prod_r[2]);
    end
  end

  assign col_o = col_r;
  assign csum  = csum_r;

endmodule

### hw/rtl/image_convolution_3x3_core.sv
// image_convolution_3x3_core: top level of the 3x3 convolution over a raster stream.
// Depends on ic3_pkg, ic3_line_store and ic3_cell.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | in_action, in_pixel
//   out     | out | out_valid/out_stall| out_value, out_col, out_row, out_frame_last
//   cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock unless stalled; each item reads and writes one line store column.
// Result n leaves via line store, cell, product, sum and output regs after item n+W+1.
// Out stall on a waiting result freezes the whole pipeline and raises in_stall;
// cfg is always ready.
// Reset clears control only; line store entries not yet written feed only masked taps.
module image_convolution_3x3_core import ic3_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  pix_t                     in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_value,
  output logic [COL_W-1:0]         out_col,
  output logic [ROW_W-1:0]         out_row,
  output logic                     out_frame_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [KROW_W-1:0]        cfg_data
);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [KROW_W-1:0] krow_r [3];

  logic [CNT_W-1:0] k_r, k_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic             pix_done_r, pix_done_nxt;
  logic [COL_W-1:0] xo_r, xo_nxt;
  logic [ROW_W-1:0] yo_r, yo_nxt;

  logic [DIM_W-1:0] eff_w, eff_h;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic             adv, accept, flush, take, have, last, cfg_clr;

  res_ctl_t s1_nxt, s1_r, s2_r, s3_r, s4_r;
  logic     s2_v_r, s3_v_r, s4_v_r;

  logic     out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [COL_W-1:0]        out_col_r;
  logic [ROW_W-1:0]        out_row_r;
  logic                    out_last_r;

  logic    ls_v;
  column_t ls_col, c2_col, c1_col;
  logic signed [CSUM_W-1:0] csum [3];
  coef_t     coef_s [3][3];
  tap_mask_t mask_s [3];

  assign eff_w = clamp_dim(width_r, MAX_WIDTH);
  assign eff_h = clamp_dim(height_r, MAX_HEIGHT);
  assign w_m1  = COL_W'(eff_w - DIM_W'(1));
  assign h_m1  = ROW_W'(eff_h - DIM_W'(1));

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign flush    = (in_action == ACT_FLUSH);
  assign take     = accept && (flush ? pix_done_r : !pix_done_r);
  assign have     = k_r > CNT_W'(eff_w);
  assign last     = have && (xo_r == w_m1) && (yo_r == h_m1);
  assign cfg_ready = 1'b1;
  assign cfg_clr  = cfg_valid &&
                    (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      krow_r[0] <= KROW_RESET;
      krow_r[1] <= KROW_MID_RESET;
      krow_r[2] <= KROW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_r   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_r  <= cfg_data[DIM_W-1:0];
        REG_KERNEL_TOP:    krow_r[0] <= cfg_data;
        REG_KERNEL_MID:    krow_r[1] <= cfg_data;
        REG_KERNEL_BOTTOM: krow_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_nxt        = k_r;
    col_nxt      = col_r;
    in_row_nxt   = in_row_r;
    pix_done_nxt = pix_done_r;
    xo_nxt       = xo_r;
    yo_nxt       = yo_r;
    if (cfg_clr || (take && last)) begin
      k_nxt        = '0;
      col_nxt      = '0;
      in_row_nxt   = '0;
      pix_done_nxt = 1'b0;
      xo_nxt       = '0;
      yo_nxt       = '0;
    end else if (take) begin
      k_nxt   = k_r + CNT_W'(1);
      col_nxt = (col_r == w_m1) ? '0 : col_r + COL_W'(1);
      if (!flush && (col_r == w_m1)) begin
        if (in_row_r == h_m1) begin
          pix_done_nxt = 1'b1;
        end else begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
      end
      if (have) begin
        if (xo_r == w_m1) begin
          xo_nxt = '0;
          yo_nxt = yo_r + ROW_W'(1);
        end else begin
          xo_nxt = xo_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      col_r      <= '0;
      in_row_r   <= '0;
      pix_done_r <= 1'b0;
      xo_r       <= '0;
      yo_r       <= '0;
    end else begin
      k_r        <= k_nxt;
      col_r      <= col_nxt;
      in_row_r   <= in_row_nxt;
      pix_done_r <= pix_done_nxt;
      xo_r       <= xo_nxt;
      yo_r       <= yo_nxt;
    end
  end

  always_comb begin
    s1_nxt.have   = have;
    s1_nxt.last   = last;
    s1_nxt.x      = xo_r;
    s1_nxt.y      = yo_r;
    s1_nxt.xl_ok  = (xo_r != '0);
    s1_nxt.xr_ok  = (xo_r != w_m1);
    s1_nxt.row_ok = {(yo_r != h_m1), 1'b1, (yo_r != '0)};
  end

  ic3_line_store u_ls (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (take),
    .in_col (col_r),
    .in_px  (flush ? pix_t'(0) : in_pixel),
    .col_v  (ls_v),
    .col_o  (ls_col)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_v_r      <= ls_v && s1_r.have;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r        <= s1_nxt;
      s2_r        <= s1_r;
      s3_r        <= s2_r;
      s4_r        <= s3_r;
      out_value_r <= VAL_W'(csum[0]) + VAL_W'(csum[1]) + VAL_W'(csum[2]);
      out_col_r   <= s4_r.x;
      out_row_r   <= s4_r.y;
      out_last_r  <= s4_r.last;
    end
  end

  // cell s holds column x-1+s; kernel is flipped for true convolution
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int j = 0; j < 3; j++) begin
        coef_s[s][j] = krow_r[2-j][COEF_STRIDE*(2-s) +: COEF_BITS];
      end
    end
    mask_s[0] = '{col_ok: s2_r.xl_ok, row_ok: s2_r.row_ok};
    mask_s[1] = '{col_ok: 1'b1,       row_ok: s2_r.row_ok};
    mask_s[2] = '{col_ok: s2_r.xr_ok, row_ok: s2_r.row_ok};
  end

  ic3_cell u_cell2 (
    .clk   (clk),
    .adv   (adv),
    .shift (adv && ls_v),
    .col_i (ls_col),
    .mask  (mask_s[2]),
    .coef  (coef_s[2]),
    .col_o (c2_col),
    .csum  (csum[2])
  );

  ic3_cell u_cell1 (
    .clk   (clk),
    .adv   (adv),
    .shift (adv && ls_v),
    .col_i (c2_col),
    .mask  (mask_s[1]),
    .coef  (coef_s[1]),
    .col_o (c1_col),
    .csum  (csum[1])
  );

  ic3_cell u_cell0 (
    .clk   (clk),
    .adv   (adv),
    .shift (adv && ls_v),
    .col_i (c1_col),
    .mask  (mask_s[0]),
    .coef  (coef_s[0]),
    .col_o (),
    .csum  (csum[0])
  );

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_last = out_last_r;

endmodule

### hw/rtl/ic3_checker.sv
// ic3_checker: port-level assertions for image_convolution_3x3_core, plus its bind.
// Depends on ic3_pkg; tracks frame size from cfg writes.
module ic3_checker import ic3_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_action,
  input pix_t                    in_pixel,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_value,
  input logic [COL_W-1:0]        out_col,
  input logic [ROW_W-1:0]        out_row,
  input logic                    out_frame_last,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [KROW_W-1:0]       cfg_data
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             seen_r;
  logic [COL_W-1:0] pcol_r;
  logic [ROW_W-1:0] prow_r;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic             oacc;

  assign w_m1 = COL_W'(clamp_dim(width_r, MAX_WIDTH) - DIM_W'(1));
  assign h_m1 = ROW_W'(clamp_dim(height_r, MAX_HEIGHT) - DIM_W'(1));
  assign oacc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      seen_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data[DIM_W-1:0];
        seen_r  <= 1'b0;
      end else if (cfg_valid && cfg_ready && cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data[DIM_W-1:0];
        seen_r   <= 1'b0;
      end else if (oacc) begin
        seen_r <= !out_frame_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oacc) begin
      pcol_r <= out_col;
      prow_r <= out_row;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_action) && $stable(in_pixel))
    else $error("stalled item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_col) &&
                               $stable(out_row) && $stable(out_frame_last))
    else $error("stalled result changed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    oacc && out_frame_last |-> out_col == w_m1 && out_row == h_m1)
    else $error("frame_last away from last pixel");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    oacc && !seen_r |-> out_col == '0 && out_row == '0)
    else $error("frame does not start at origin");

  a_raster: assert property (@(posedge clk) disable iff (!rst_n)
    oacc && seen_r |->
      (out_col == COL_W'(pcol_r + COL_W'(1)) && out_row == prow_r) ||
      (out_col == '0 && pcol_r == w_m1 && out_row == ROW_W'(prow_r + ROW_W'(1))))
    else $error("results out of raster order");

endmodule

bind image_convolution_3x3_core ic3_checker u_ic3_checker (.*);

### bench/tb.sv
// tb: self-checking bench for image_convolution_3x3_core, a 3x3 convolution over a pixel stream.
// Depends on ic3_pkg and the core; a scoreboard class predicts each result from accepted items.
// Random frames, kernels and sizes are sent with random gaps and output stalls.
`timescale 1ns / 1ps

module tb;
  import ic3_pkg::*;

  localparam int ITEMS_TARGET = 750;
  localparam int IDLE_CYCLES  = 12;
  localparam int LIMIT_CYCLES = 4_000_000;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } conv_result_t;

  class conv_scoreboard;
    int unsigned         width_reg;
    int unsigned         height_reg;
    logic [KROW_W-1:0]   krow[3];
    pix_t                prev_line[MAX_WIDTH];
    pix_t                older_line[MAX_WIDTH];
    pix_t                win[9];
    int unsigned         taken;
    int unsigned         given;
    conv_result_t        pending_results[$];
    int                  mismatches;

    function new();
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      krow[0]    = KROW_RESET;
      krow[1]    = KROW_MID_RESET;
      krow[2]    = KROW_RESET;
      foreach (prev_line[i]) begin
        prev_line[i]  = '0;
        older_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      taken      = 0;
      given      = 0;
      mismatches = 0;
    endfunction

    static function int unsigned span(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("tb: mismatch: %s", msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data[DIM_W-1:0];
          taken     = 0;
          given     = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[DIM_W-1:0];
          taken      = 0;
          given      = 0;
        end
        REG_KERNEL_TOP:    krow[0] = data;
        REG_KERNEL_MID:    krow[1] = data;
        REG_KERNEL_BOTTOM: krow[2] = data;
        default: ;
      endcase
    endfunction

    // at_right: window slots 1,2 hold columns x-1,x; else slots 0..2 hold x-1..x+1
    function longint tap_sum(int unsigned x, int unsigned y, int unsigned w, int unsigned h,
                             bit at_right);
      longint acc;
      acc = 0;
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          int cx;
          int cy;
          int slot;
          logic signed [COEF_BITS-1:0] k;
          cx   = int'(x) + dx;
          cy   = int'(y) + dy;
          slot = at_right ? dx + 2 : dx + 1;
          if (cx >= 0 && cx < int'(w) && slot <= 2 && cy >= 0 && cy < int'(h)) begin
            k   = krow[1 - dy][COEF_STRIDE * (1 - dx) +: COEF_BITS];
            acc += longint'(win[slot * 3 + dy + 1]) * longint'(k);
          end
        end
      end
      return acc;
    endfunction

    function void take_item(logic act, pix_t pixel);
      int unsigned  w, h, total, k, col, n, xo, yo;
      bit           have, at_right;
      pix_t         px;
      longint       acc;
      conv_result_t r;
      w     = span(width_reg, MAX_WIDTH);
      h     = span(height_reg, MAX_HEIGHT);
      total = w * h;
      if (act == ACT_FLUSH) begin
        if (taken < total) return;
        px = '0;
      end else begin
        if (taken >= total) return;
        px = pixel;
      end
      k        = taken;
      col      = k % w;
      have     = 0;
      at_right = 0;
      n        = 0;
      xo       = 0;
      yo       = 0;
      acc      = 0;
      if (k >= w + 1) begin
        have     = 1;
        n        = k - (w + 1);
        xo       = n % w;
        yo       = n / w;
        at_right = (xo == w - 1);
      end
      if (have && at_right) acc = tap_sum(xo, yo, w, h, 1'b1);
      for (int i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6]          = older_line[col];
      win[7]          = prev_line[col];
      win[8]          = px;
      older_line[col] = prev_line[col];
      prev_line[col]  = px;
      if (have && !at_right) acc = tap_sum(xo, yo, w, h, 1'b0);
      taken = k + 1;
      if (!have) return;
      given   = n + 1;
      r.value = acc[VAL_W-1:0];
      r.col   = xo[COL_W-1:0];
      r.row   = yo[ROW_W-1:0];
      r.last  = (n == total - 1);
      pending_results.push_back(r);
      if (r.last) begin
        taken = 0;
        given = 0;
      end
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row, logic last);
      conv_result_t r;
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result value %0d col %0d row %0d last %0b",
                       value, col, row, last));
        return;
      end
      r = pending_results.pop_front();
      if (value !== r.value || col !== r.col || row !== r.row || last !== r.last)
        flag($sformatf("exp value %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                       r.value, r.col, r.row, r.last, value, col, row, last));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_action = ACT_PIXEL;
  pix_t                    in_pixel = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_value;
  logic [COL_W-1:0]        out_col;
  logic [ROW_W-1:0]        out_row;
  logic                    out_frame_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [KROW_W-1:0]       cfg_data = '0;

  conv_scoreboard sb;
  bit             idle_on = 1'b0;
  int             rx_hold = 0;
  int             fed = 0;
  int unsigned    cycle_count = 0;
  logic [DIM_W-1:0] gen_w_raw, gen_h_raw;
  int unsigned    gen_w, gen_h;

  image_convolution_3x3_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall)
        sb.check_result(out_value, out_col, out_row, out_frame_last);
      if (in_valid && !in_stall) sb.take_item(in_action, in_pixel);
    end
  end

  // receiver: random stall runs, plus long holds on request
  initial begin : receiver
    int run_left;
    int r;
    run_left = 0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 45) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(12);
        end else if (r < 85) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(2);
        end else if (r < 97) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(15, 3);
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(80, 30);
        end
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    case ($urandom_range(5))
      0:       return {3{16'h7FFF}};
      1:       return {3{16'h8000}};
      default: return {16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
  endfunction

  task automatic push_item(logic act, pix_t px);
    int gap;
    gap = pick_gap();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_pixel  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait until every result is in and the pipeline has run empty
  task automatic settle();
    int calm;
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    calm = 0;
    while (calm < IDLE_CYCLES) begin
      @(posedge clk);
      calm = (out_stall || sb.pending_results.size() != 0) ? 0 : calm + 1;
    end
  endtask

  task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_cfg(REG_IMAGE_WIDTH, KROW_W'(w));
    write_cfg(REG_IMAGE_HEIGHT, KROW_W'(h));
    gen_w_raw = w;
    gen_h_raw = h;
    gen_w     = conv_scoreboard::span(w, MAX_WIDTH);
    gen_h     = conv_scoreboard::span(h, MAX_HEIGHT);
  endtask

  task automatic set_kernel(logic [KROW_W-1:0] k0, logic [KROW_W-1:0] k1,
                            logic [KROW_W-1:0] k2);
    write_cfg(REG_KERNEL_TOP, k0);
    write_cfg(REG_KERNEL_MID, k1);
    write_cfg(REG_KERNEL_BOTTOM, k2);
  endtask

  // style 0: mixed random pixels, 1: all full-scale
  task automatic run_frame(int style);
    int unsigned total, pause_at, stop_at, r;
    pix_t        px;
    total    = gen_w * gen_h;
    pause_at = ($urandom_range(5) == 0) ? $urandom_range(total - 1) : total;
    stop_at  = ($urandom_range(9) == 0 && total > 1) ? $urandom_range(total - 1, 1) : total;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == stop_at) begin
        // abandon the frame; a size write restarts it
        settle();
        set_dims(gen_w_raw, gen_h_raw);
        return;
      end
      if (i == pause_at && i > 0) begin
        settle();
        write_cfg(CFG_IDX_W'(REG_KERNEL_TOP + $urandom_range(2)), rand_krow());
      end
      if ($urandom_range(30) == 0) push_item(ACT_FLUSH, pix_t'($urandom));
      r  = $urandom_range(7);
      px = (style == 1) ? 8'hFF : (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : pix_t'($urandom);
      push_item(ACT_PIXEL, px);
      fed++;
    end
    if ($urandom_range(4) == 0) push_item(ACT_PIXEL, pix_t'($urandom));
    for (int unsigned i = 0; i <= gen_w; i++) begin
      push_item(ACT_FLUSH, pix_t'($urandom));
      fed++;
    end
    if ($urandom_range(6) == 0) push_item(ACT_FLUSH, pix_t'($urandom));
  endtask

  initial begin : stimulus
    int r;
    logic [DIM_W-1:0] w, h;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: a few pixels, then a size write drops the partial frame
    push_item(ACT_PIXEL, 8'h12);
    push_item(ACT_PIXEL, 8'hED);
    push_item(ACT_PIXEL, 8'hFF);
    settle();
    set_dims(11'd3, 11'd2);
    set_kernel({16'h0001, 16'h8000, 16'h7FFF}, {16'hF000, 16'h1000, 16'h0800},
               {16'h7FFF, 16'hFFFF, 16'h8000});
    push_item(ACT_PIXEL, 8'h00);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_FLUSH, 8'hFF);  // early flush, ignored
    push_item(ACT_PIXEL, 8'h55);
    push_item(ACT_PIXEL, 8'hAA);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h01);
    push_item(ACT_PIXEL, 8'h80);  // past the frame, ignored
    repeat (4) push_item(ACT_FLUSH, 8'h00);
    push_item(ACT_FLUSH, 8'h00);  // nothing pending, ignored
    settle();
    // zero sizes clamp to a single pixel; first flush has no result yet
    set_dims(11'd0, 11'd0);
    push_item(ACT_PIXEL, 8'hC8);
    push_item(ACT_FLUSH, 8'h00);
    push_item(ACT_FLUSH, 8'h00);
    settle();

    idle_on = 1'b1;
    set_dims(11'd4, 11'd3);
    set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    run_frame(1);
    settle();
    set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    run_frame(1);
    settle();

    // long output hold while the sender keeps offering
    set_dims(11'd8, 11'd6);
    set_kernel(rand_krow(), rand_krow(), rand_krow());
    rx_hold = 400;
    run_frame(0);
    settle();

    while (fed < ITEMS_TARGET) begin
      r = $urandom_range(99);
      if (r < 70) begin
        w = DIM_W'($urandom_range(10, 1));
        h = DIM_W'($urandom_range(6, 1));
      end else if (r < 88) begin
        w = DIM_W'($urandom_range(40, 11));
        h = DIM_W'($urandom_range(4, 1));
      end else begin
        w = DIM_W'($urandom_range(2));
        h = DIM_W'($urandom_range(3));
      end
      set_dims(w, h);
      repeat ($urandom_range(3, 1))
        write_cfg(CFG_IDX_W'(REG_KERNEL_TOP + $urandom_range(2)), rand_krow());
      idle_on = ($urandom_range(4) != 0);
      if ($urandom_range(7) == 0) rx_hold = $urandom_range(200, 60);
      repeat ($urandom_range(3, 1)) run_frame(($urandom_range(15) == 0) ? 1 : 0);
      settle();
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### image_convolution_3x3_core.f
hw/rtl/ic3_pkg.sv
hw/rtl/ic3_line_store.sv
hw/rtl/ic3_cell.sv
hw/rtl/image_convolution_3x3_core.sv
hw/rtl/ic3_checker.sv
bench/tb.sv
